FILE: sv/dhfd_pkg.sv
package dhfd_pkg;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'hFF;

    localparam int CRC_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int HEIGHT_W  = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [7:0] DIGIT_MAX    = 8'd9;
    localparam logic [7:0] TENS_LOW_MAX = 8'd2;
    localparam logic [7:0] TENS_HI_MIN  = 8'd10;
    localparam logic [7:0] TENS_HI_MAX  = 8'd19;
    localparam logic [7:0] HUND_SKIP    = 8'd5;

    localparam logic [CRC_W-1:0] POLY_RST    = 16'h8005;
    localparam logic [CRC_W-1:0] INIT_RST    = 16'hFFFF;
    localparam logic [CRC_W-1:0] XOR_OUT_RST = 16'h0000;
    localparam logic             REFL_IN_RST  = 1'b1;
    localparam logic             REFL_OUT_RST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] IDX_POLY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_INIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_XOR_OUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_REFL_IN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_REFL_OUT = 3'd4;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init;
        logic [CRC_W-1:0] xor_out;
        logic             reflect_in;
        logic             reflect_out;
    } t_cfg;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // one byte through the CRC register, eight shifts
    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input t_cfg              cfg
    );
        logic [CRC_W-1:0]  r;
        logic [BYTE_W-1:0] d;
        d = cfg.reflect_in ? rev8(data) : data;
        r = crc ^ {d, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ cfg.poly;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/desk_height_frame_decoder_unit.sv
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_rx_byte[7:0]
// out      output     o_out_valid / i_out_ready  o_frame_good, o_height_tenths[13:0]
// cfg      input      i_cfg_wr_en                i_cfg_index[2:0], i_cfg_wdata[15:0]
//
// One transaction per cycle when not stalled; a byte goes from the input to the result register.
// The rate is set by the single parse stage: byte-wide CRC update and digit checks.
// Synchronous active-low reset returns the parser to hunting for the first sync byte
// and loads the CRC registers with their defaults.
// A stalled output holds its result. After any settings write the input stalls
// while the frame bytes held so far are run through the CRC again.
module desk_height_frame_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dhfd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_frame_good,
    output logic [dhfd_pkg::HEIGHT_W-1:0]   o_height_tenths,
    input  logic                            i_cfg_wr_en,
    input  logic [dhfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dhfd_pkg::CFG_DAT_W-1:0]  i_cfg_wdata
);

    dhfd_pkg::t_cfg                  w_cfg;
    logic                            r_in_valid;
    logic [dhfd_pkg::BYTE_W-1:0]     r_in_byte;
    logic                            r_out_valid;
    logic                            r_out_good;
    logic [dhfd_pkg::HEIGHT_W-1:0]   r_out_height;
    logic                            w_adv;
    logic                            w_step;
    logic                            w_busy;
    logic                            w_good;
    logic [dhfd_pkg::HEIGHT_W-1:0]   w_height;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv && !w_busy;
    assign o_in_ready = !r_in_valid || (w_adv && !w_busy);

    dhfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    dhfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .i_cfg_wr (i_cfg_wr_en),
        .o_busy   (w_busy),
        .o_good   (w_good),
        .o_height (w_height)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) r_in_byte <= i_rx_byte;
            end
            if (w_adv) begin
                r_out_valid <= w_step;
                if (w_step) begin
                    r_out_good   <= w_good;
                    r_out_height <= w_height;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_good    = r_out_good;
    assign o_height_tenths = r_out_height;

endmodule

FILE: sv/dhfd_cfg.sv
module dhfd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dhfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dhfd_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    output dhfd_pkg::t_cfg                  o_cfg
);

    dhfd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly        <= dhfd_pkg::POLY_RST;
            r_cfg.init        <= dhfd_pkg::INIT_RST;
            r_cfg.xor_out     <= dhfd_pkg::XOR_OUT_RST;
            r_cfg.reflect_in  <= dhfd_pkg::REFL_IN_RST;
            r_cfg.reflect_out <= dhfd_pkg::REFL_OUT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dhfd_pkg::IDX_POLY:     r_cfg.poly        <= i_cfg_wdata;
                dhfd_pkg::IDX_INIT:     r_cfg.init        <= i_cfg_wdata;
                dhfd_pkg::IDX_XOR_OUT:  r_cfg.xor_out     <= i_cfg_wdata;
                dhfd_pkg::IDX_REFL_IN:  r_cfg.reflect_in  <= i_cfg_wdata[0];
                dhfd_pkg::IDX_REFL_OUT: r_cfg.reflect_out <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/dhfd_parser.sv
module dhfd_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [dhfd_pkg::BYTE_W-1:0]     i_byte,
    input  dhfd_pkg::t_cfg                  i_cfg,
    input  logic                            i_cfg_wr,
    output logic                            o_busy,
    output logic                            o_good,
    output logic [dhfd_pkg::HEIGHT_W-1:0]   o_height
);

    typedef enum logic [2:0] {
        ST_SYNC_A,
        ST_SYNC_B,
        ST_ONES,
        ST_TENS,
        ST_HUND,
        ST_CRC_LO,
        ST_CRC_HI
    } t_state;

    t_state                       r_state, n_state;
    logic [3:0]                   r_ones;
    logic [4:0]                   r_tens;
    logic [3:0]                   r_hund;
    logic [7:0]                   r_crc_lo;
    logic [dhfd_pkg::CRC_W-1:0]   r_crc, n_crc;
    logic [dhfd_pkg::CRC_W-1:0]   w_crc_fed;
    logic [dhfd_pkg::CRC_W-1:0]   w_crc_final;
    logic                         w_crc_match;
    logic [dhfd_pkg::HEIGHT_W-1:0] w_base;
    logic [dhfd_pkg::HEIGHT_W-1:0] w_height;
    logic                         r_rc_busy;
    logic [2:0]                   r_rc_cnt;
    logic [2:0]                   w_rc_need;
    logic [dhfd_pkg::BYTE_W-1:0]  w_rc_byte;
    logic [dhfd_pkg::CRC_W-1:0]   w_rc_fed;

    // running CRC, seeded from init on the first sync byte
    assign w_crc_fed = dhfd_pkg::crc_feed((r_state == ST_SYNC_A) ? i_cfg.init : r_crc,
                                          i_byte, i_cfg);

    // after a settings write, rerun the bytes held so far, one per cycle
    always_comb begin
        case (r_state)
            ST_SYNC_B:            w_rc_need = 3'd1;
            ST_ONES:              w_rc_need = 3'd2;
            ST_TENS:              w_rc_need = 3'd3;
            ST_HUND:              w_rc_need = 3'd4;
            ST_CRC_LO, ST_CRC_HI: w_rc_need = 3'd5;
            default:              w_rc_need = 3'd0;
        endcase
    end

    always_comb begin
        case (r_rc_cnt)
            3'd0:    w_rc_byte = dhfd_pkg::SYNC_A;
            3'd1:    w_rc_byte = dhfd_pkg::SYNC_B;
            3'd2:    w_rc_byte = {4'd0, r_ones};
            3'd3:    w_rc_byte = {3'd0, r_tens};
            default: w_rc_byte = {4'd0, r_hund};
        endcase
    end

    assign w_rc_fed = dhfd_pkg::crc_feed((r_rc_cnt == 3'd0) ? i_cfg.init : r_crc,
                                         w_rc_byte, i_cfg);
    assign o_busy   = r_rc_busy && (r_rc_cnt != w_rc_need);

    assign w_crc_final = (i_cfg.reflect_out ? dhfd_pkg::rev16(r_crc) : r_crc)
                         ^ i_cfg.xor_out;
    assign w_crc_match = (r_crc_lo == w_crc_final[7:0]) && (i_byte == w_crc_final[15:8]);

    always_comb begin
        if (r_tens >= 5'(dhfd_pkg::TENS_HI_MIN)) begin
            w_base   = 14'(r_hund) * 14'd100 + 14'(r_tens - 5'(dhfd_pkg::TENS_HI_MIN)) * 14'd10
                       + 14'(r_ones);
            w_height = w_base;
        end else begin
            w_base   = 14'(r_hund) * 14'd100 + 14'(r_tens) * 14'd10 + 14'(r_ones);
            w_height = w_base * 14'd10;
        end
    end

    always_comb begin
        n_state  = ST_SYNC_A;
        n_crc    = w_crc_fed;
        o_good   = 1'b0;
        o_height = '0;
        case (r_state)
            ST_SYNC_B: begin
                if (i_byte == dhfd_pkg::SYNC_B) n_state = ST_ONES;
            end
            ST_ONES: begin
                if (i_byte <= dhfd_pkg::DIGIT_MAX) n_state = ST_TENS;
            end
            ST_TENS: begin
                if (i_byte <= dhfd_pkg::TENS_LOW_MAX ||
                    (i_byte >= dhfd_pkg::TENS_HI_MIN && i_byte <= dhfd_pkg::TENS_HI_MAX)) begin
                    n_state = ST_HUND;
                end
            end
            ST_HUND: begin
                if (i_byte <= dhfd_pkg::DIGIT_MAX && i_byte != dhfd_pkg::HUND_SKIP) begin
                    n_state = ST_CRC_LO;
                end
            end
            ST_CRC_LO: begin
                n_state = ST_CRC_HI;
                n_crc   = r_crc;
            end
            ST_CRC_HI: begin
                n_crc = r_crc;
                if (i_step && w_crc_match) begin
                    o_good   = 1'b1;
                    o_height = w_height;
                end
            end
            default: begin
                if (i_byte == dhfd_pkg::SYNC_A) n_state = ST_SYNC_B;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SYNC_A;
            r_rc_busy <= 1'b0;
            r_rc_cnt  <= '0;
        end else begin
            if (i_step) begin
                r_state <= n_state;
                r_crc   <= n_crc;
                case (r_state)
                    ST_ONES:   r_ones   <= i_byte[3:0];
                    ST_TENS:   r_tens   <= i_byte[4:0];
                    ST_HUND:   r_hund   <= i_byte[3:0];
                    ST_CRC_LO: r_crc_lo <= i_byte;
                    default: ;
                endcase
            end else if (o_busy) begin
                r_crc <= w_rc_fed;
            end
            if (i_cfg_wr) begin
                r_rc_busy <= 1'b1;
                r_rc_cnt  <= '0;
            end else if (o_busy) begin
                r_rc_cnt  <= r_rc_cnt + 3'd1;
            end else begin
                r_rc_busy <= 1'b0;
            end
        end
    end

    a_good_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_good |-> (i_step && r_state == ST_CRC_HI))
        else $error("frame good outside the last CRC byte");

    a_end_returns_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_state == ST_CRC_HI) |=> (r_state == ST_SYNC_A))
        else $error("parser did not return to hunting after a frame");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_state))
        else $error("parse state moved without a byte");

    a_no_step_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !i_step)
        else $error("byte taken while the CRC was being rebuilt");

endmodule

FILE: dv/dhfd_checker.sv
`timescale 1ns / 1ps

package dhfd_tb_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'hFF;

    // Bit-serial CRC over the five leading frame bytes.
    function automatic logic [15:0] desk_frame_crc(
        input dhfd_pkg::t_cfg cfg,
        input logic [7:0]     ones,
        input logic [7:0]     tens,
        input logic [7:0]     hund
    );
        logic [39:0] stream;
        logic [7:0]  cur;
        logic [15:0] acc;
        logic [15:0] flipped;
        logic        fb;
        stream = {SYNC_FIRST, SYNC_SECOND, ones, tens, hund};
        acc = cfg.init;
        for (int k = 0; k < 5; k++) begin
            cur = stream[39 - 8*k -: 8];
            for (int b = 0; b < 8; b++) begin
                fb = acc[15] ^ (cfg.reflect_in ? cur[b] : cur[7-b]);
                acc = {acc[14:0], 1'b0};
                if (fb) begin
                    acc = acc ^ cfg.poly;
                end
            end
        end
        for (int b = 0; b < 16; b++) begin
            flipped[15-b] = acc[b];
        end
        if (cfg.reflect_out) begin
            acc = flipped;
        end
        return acc ^ cfg.xor_out;
    endfunction

endpackage

module dhfd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [dhfd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_frame_good,
    input  logic [dhfd_pkg::HEIGHT_W-1:0]   i_height_tenths,
    input  logic                            i_cfg_wr_en,
    input  logic [dhfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dhfd_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    output int                              o_pending,
    output int                              o_fail_count,
    output int                              o_good_frames
);
    import dhfd_pkg::*;
    import dhfd_tb_pkg::*;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        GET_ONES,
        GET_TENS,
        GET_HUND,
        GET_CRC_LO,
        GET_CRC_HI
    } parse_t;

    typedef struct packed {
        logic                good;
        logic [HEIGHT_W-1:0] height;
    } reading_t;

    t_cfg       cfg_now;
    parse_t     st;
    logic [3:0] ones_q;
    logic [4:0] tens_q;
    logic [3:0] hund_q;
    logic [7:0] crc_lo_q;
    reading_t   due_q[$];
    int         fails = 0;
    int         goods = 0;

    initial begin
        o_pending     = 0;
        o_fail_count  = 0;
        o_good_frames = 0;
    end

    task automatic report_mismatch(input string what);
        fails++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function automatic logic [HEIGHT_W-1:0] height_of(
        input logic [3:0] o,
        input logic [4:0] t,
        input logic [3:0] h
    );
        int v;
        if (t >= 10) begin
            v = h * 100 + (t - 10) * 10 + o;
        end else begin
            v = (h * 100 + t * 10 + o) * 10;
        end
        return v[HEIGHT_W-1:0];
    endfunction

    function automatic reading_t advance(input logic [7:0] b);
        reading_t   r;
        logic [15:0] crc;
        r = '0;
        case (st)
            HUNT_SECOND: st = (b == SYNC_SECOND) ? GET_ONES : HUNT_FIRST;
            GET_ONES: begin
                if (b > 9) begin
                    st = HUNT_FIRST;
                end else begin
                    ones_q = b[3:0];
                    st = GET_TENS;
                end
            end
            GET_TENS: begin
                if (b > 2 && (b < 10 || b > 19)) begin
                    st = HUNT_FIRST;
                end else begin
                    tens_q = b[4:0];
                    st = GET_HUND;
                end
            end
            GET_HUND: begin
                if (b > 9 || b == 5) begin
                    st = HUNT_FIRST;
                end else begin
                    hund_q = b[3:0];
                    st = GET_CRC_LO;
                end
            end
            GET_CRC_LO: begin
                crc_lo_q = b;
                st = GET_CRC_HI;
            end
            GET_CRC_HI: begin
                crc = desk_frame_crc(cfg_now, {4'd0, ones_q}, {3'd0, tens_q}, {4'd0, hund_q});
                st = HUNT_FIRST;
                if (crc == {b, crc_lo_q}) begin
                    r.good = 1'b1;
                    r.height = height_of(ones_q, tens_q, hund_q);
                end
            end
            default: st = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        reading_t want;
        if (!i_rst_n) begin
            cfg_now = '{poly: POLY_RST, init: INIT_RST, xor_out: XOR_OUT_RST,
                        reflect_in: REFL_IN_RST, reflect_out: REFL_OUT_RST};
            st = HUNT_FIRST;
            ones_q = '0;
            tens_q = '0;
            hund_q = '0;
            crc_lo_q = '0;
            due_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    IDX_POLY:     cfg_now.poly        = i_cfg_wdata;
                    IDX_INIT:     cfg_now.init        = i_cfg_wdata;
                    IDX_XOR_OUT:  cfg_now.xor_out     = i_cfg_wdata;
                    IDX_REFL_IN:  cfg_now.reflect_in  = i_cfg_wdata[0];
                    IDX_REFL_OUT: cfg_now.reflect_out = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                due_q.push_back(advance(i_rx_byte));
            end
            if (i_out_valid && i_out_ready) begin
                if (due_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = due_q.pop_front();
                    if (i_frame_good !== want.good) begin
                        report_mismatch($sformatf("frame_good got %b want %b",
                                                  i_frame_good, want.good));
                    end
                    if (i_height_tenths !== want.height) begin
                        report_mismatch($sformatf("height_tenths got %0d want %0d",
                                                  i_height_tenths, want.height));
                    end
                    if (want.good) begin
                        goods++;
                    end
                end
            end
        end
        o_pending     <= due_q.size();
        o_fail_count  <= fails;
        o_good_frames <= goods;
    end

endmodule

FILE: dv/desk_height_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps

module desk_height_frame_decoder_unit_tb;
    import dhfd_pkg::*;
    import dhfd_tb_pkg::*;

    localparam int                   CYCLE_LIMIT  = 1_000_000;
    localparam int                   RANDOM_BYTES = 1400;
    localparam int                   N_PHASES     = 6;
    localparam int                   SETTLE       = 8;
    localparam logic [7:0]           FLUSH_BYTE   = 8'h20;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP      = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 frame_good;
    logic [HEIGHT_W-1:0]  height_tenths;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    int   pending;
    int   fail_count;
    int   good_frames;
    int   bytes_sent;
    int   settings_run;
    int   cycles;
    int   hold_left;
    bit   calm;
    t_cfg reg_shadow;

    desk_height_frame_decoder_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_frame_good    (frame_good),
        .o_height_tenths (height_tenths),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    dhfd_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_frame_good    (frame_good),
        .i_height_tenths (height_tenths),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_good_frames   (good_frames)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("desk_height_frame_decoder_unit_tb failed");
                $finish;
            end
        end
    end

    // result-side backpressure
    initial begin
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (calm || !rst_n) begin
                out_ready <= 1'b1;
            end else if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) begin
                    case ($urandom_range(0, 19))
                        0:         hold_left = $urandom_range(20, 80);
                        1, 2, 3:   hold_left = $urandom_range(4, 12);
                        default:   hold_left = $urandom_range(1, 3);
                    endcase
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            IDX_POLY:     reg_shadow.poly        = data;
            IDX_INIT:     reg_shadow.init        = data;
            IDX_XOR_OUT:  reg_shadow.xor_out     = data;
            IDX_REFL_IN:  reg_shadow.reflect_in  = data[0];
            IDX_REFL_OUT: reg_shadow.reflect_out = data[0];
            default: ;
        endcase
    endtask

    // park the parser in hunt state before touching the CRC settings
    task automatic apply_setting(input logic [15:0] poly, input logic [15:0] init,
                                 input logic [15:0] xo, input logic rin, input logic rout);
        put_byte(FLUSH_BYTE);
        put_byte(FLUSH_BYTE);
        wait_drained();
        write_reg(IDX_POLY, poly);
        write_reg(IDX_INIT, init);
        write_reg(IDX_XOR_OUT, xo);
        write_reg(IDX_REFL_IN, {15'($urandom), rin});
        write_reg(IDX_REFL_OUT, {15'($urandom), rout});
        write_reg(IDX_TOP - 3'($urandom_range(0, 2)), 16'($urandom));
        settings_run++;
    endtask

    task automatic send_frame(input logic [7:0] ones, input logic [7:0] tens,
                              input logic [7:0] hund, input bit bad_crc);
        logic [15:0] crc;
        crc = desk_frame_crc(reg_shadow, ones, tens, hund);
        if (bad_crc) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        put_byte(SYNC_FIRST);
        put_byte(SYNC_SECOND);
        put_byte(ones);
        put_byte(tens);
        put_byte(hund);
        put_byte(crc[7:0]);
        put_byte(crc[15:8]);
    endtask

    task automatic send_broken();
        int slot;
        slot = $urandom_range(1, 4);
        put_byte(SYNC_FIRST);
        if (slot == 1) begin
            put_byte(8'($urandom_range(0, 254)));
        end else begin
            put_byte(SYNC_SECOND);
            if (slot == 2) begin
                put_byte(8'($urandom_range(10, 255)));
            end else begin
                put_byte(8'($urandom_range(0, 9)));
                if (slot == 3) begin
                    put_byte($urandom_range(0, 1) ? 8'($urandom_range(3, 9))
                                                  : 8'($urandom_range(20, 255)));
                end else begin
                    put_byte(8'($urandom_range(0, 2)));
                    put_byte($urandom_range(0, 1) ? 8'd5 : 8'($urandom_range(10, 255)));
                end
            end
        end
    endtask

    task automatic random_step();
        int          r;
        int          k;
        logic [7:0]  hund;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 199) == 0) begin
            calm = !calm;
        end
        if ($urandom_range(0, 299) == 0) begin
            wait_drained();
        end
        if (r < 70) begin
            hund = 8'($urandom_range(0, 8));
            if (hund >= 5) begin
                hund = hund + 8'd1;
            end
            send_frame(8'($urandom_range(0, 9)),
                       $urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                            : 8'($urandom_range(10, 19)),
                       hund, $urandom_range(0, 99) < 15);
        end else if (r < 85) begin
            send_broken();
        end else begin
            k = $urandom_range(1, 6);
            repeat (k) begin
                r = $urandom_range(0, 9);
                put_byte(r < 2 ? SYNC_FIRST : r < 3 ? SYNC_SECOND : 8'($urandom));
            end
        end
    endtask

    initial begin
        int target;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        out_ready  = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        calm       = 1'b0;
        bytes_sent = 0;
        settings_run = 1;
        reg_shadow = '{poly: POLY_RST, init: INIT_RST, xor_out: XOR_OUT_RST,
                       reflect_in: REFL_IN_RST, reflect_out: REFL_OUT_RST};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: hunting bytes, smallest and largest heights, CRC mismatch, bad digit
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(8'd0, 8'd0, 8'd0, 1'b0);
        send_frame(8'd9, 8'd2, 8'd9, 1'b0);
        send_frame(8'd9, 8'd19, 8'd9, 1'b1);
        put_byte(SYNC_FIRST);
        put_byte(SYNC_FIRST);
        put_byte(SYNC_SECOND);
        put_byte(8'd10);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                1: apply_setting(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
                2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
                3: apply_setting(16'h1021, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
                4: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b0);
                5: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b1);
                default: ;
            endcase
            target = bytes_sent + RANDOM_BYTES / N_PHASES;
            while (bytes_sent < target) begin
                random_step();
            end
        end

        wait_drained();
        $display("run covered %0d bytes under %0d CRC settings, %0d frames decoded good",
                 bytes_sent, settings_run, good_frames);
        if (fail_count == 0) begin
            $display("desk_height_frame_decoder_unit_tb passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("desk_height_frame_decoder_unit_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/dhfd_pkg.sv
sv/dhfd_cfg.sv
sv/dhfd_parser.sv
sv/desk_height_frame_decoder_unit.sv
dv/dhfd_checker.sv
dv/desk_height_frame_decoder_unit_tb.sv
